>>> design/assert_macros.svh
// Assertion macros used by the top level of the pattern test engine RTL.
// Each macro expands to one labeled concurrent assertion, clocked and reset-gated.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever cond holds, expr holds too.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error("assertion failed");

// Next-cycle implication: when cond holds, expr holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error("assertion failed");

`endif

>>> design/dpte_pkg.sv
// Package for the memory pattern test engine: codes, register indexes, config type.
// Used by the top level, dpte_cfg and dpte_seq; depends on nothing.
`default_nettype none

package dpte_pkg;

	// Input operation codes
	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	// Test pass, as reported on test_phase
	typedef enum logic [1:0] {
		PH_IDLE       = 2'd0,
		PH_WRITE      = 2'd1,
		PH_VERIFY_CPL = 2'd2,
		PH_VERIFY     = 2'd3
	} phase_t;

	// Test status, as reported on test_status
	typedef enum logic [2:0] {
		ST_RUNNING      = 3'd0,
		ST_PASSED       = 3'd1,
		ST_PAT_MISMATCH = 3'd2,
		ST_CPL_MISMATCH = 3'd3,
		ST_BAD_MODE     = 3'd4
	} status_t;

	// Test modes; any code with the top bit set is invalid
	localparam logic [1:0] MODE_EXHAUSTIVE = 2'd0;
	localparam logic [1:0] MODE_SPARSE     = 2'd1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEST_LENGTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_PATTERN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SPAN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WORDS_PER_STEP = 3'd5;

	// Register reset values
	localparam logic [31:0] PATTERN_RST = 32'h5555_5555;
	localparam logic [20:0] SPAN_RST    = 21'd4096;
	localparam logic [7:0]  WPS_RST     = 8'd1;

	// Configuration register set
	typedef struct packed {
		logic [31:0] base_address;
		logic [31:0] test_length;
		logic [1:0]  test_mode;
		logic [31:0] data_pattern;
		logic [20:0] step_span;
		logic [7:0]  words_per_step;
	} cfg_t;

endpackage

`default_nettype wire

>>> design/dram_pattern_test_engine.sv
// Top level of the memory pattern/complement test engine.
// Depends on dpte_pkg, dpte_cfg, dpte_stage, dpte_seq and assert_macros.svh.
//
// Usage: write the six configuration registers through cfg_write/cfg_index/
// cfg_data while the engine is idle. Send an item with operation 0 to start
// the test, then one item with operation 1 per memory command slot; each
// item carries read_data for the read issued by the previous item. Every
// input transaction yields exactly one result transaction with the command
// to issue (cmd_valid/cmd_write/cmd_address/cmd_data) and the test progress
// (test_phase, test_status, fail_address, fail_data).
// Path: an accepted input passes the input register, then the sequencer logic into the
// result register, from which it leaves when out_stall is low.
// Throughput: one item per cycle while the result channel does not stall; the sequencer
// updates its counters in the same cycle the item leaves the input register.
// Stall: when out_stall holds a result and the input register is also full,
// in_stall rises in that cycle; nothing is lost or repeated.
// Reset: arst_n clears both stages and the test state to idle/running and
// loads the register reset values; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module dram_pattern_test_engine #(
	parameter int ADDR_WIDTH = 32,
	parameter int DATA_WIDTH = 32,
	parameter int WORD_BYTES = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_write,
	input  wire logic [dpte_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dpte_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               operation,
	input  wire logic [DATA_WIDTH-1:0]              read_data,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    cmd_valid,
	output logic                                    cmd_write,
	output logic [ADDR_WIDTH-1:0]                   cmd_address,
	output logic [DATA_WIDTH-1:0]                   cmd_data,
	output logic [1:0]                              test_phase,
	output logic [2:0]                              test_status,
	output logic [ADDR_WIDTH-1:0]                   fail_address,
	output logic [DATA_WIDTH-1:0]                   fail_data
);

	localparam int IN_W  = 1 + DATA_WIDTH;
	localparam int RES_W = 2 + 2 * ADDR_WIDTH + 2 * DATA_WIDTH + 2 + 3;

	dpte_pkg::cfg_t    cfg;
	logic              valid_s1;
	logic [IN_W-1:0]   data_s1;
	logic              stall_s2;
	logic              fire;
	logic [RES_W-1:0]  res;
	logic [RES_W-1:0]  data_s2;

	dpte_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register
	dpte_stage #(.WIDTH(IN_W)) u_stage_s1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_stall (in_stall),
		.up_data  ({operation, read_data}),
		.dn_valid (valid_s1),
		.dn_stall (stall_s2),
		.dn_data  (data_s1)
	);

	// Sequencer steps once per transaction leaving the input register
	assign fire = valid_s1 && !stall_s2;

	dpte_seq #(
		.ADDR_WIDTH (ADDR_WIDTH),
		.DATA_WIDTH (DATA_WIDTH),
		.WORD_BYTES (WORD_BYTES),
		.RES_WIDTH  (RES_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.operation (data_s1[IN_W-1]),
		.read_data (data_s1[DATA_WIDTH-1:0]),
		.cfg       (cfg),
		.res       (res)
	);

	// Result register
	dpte_stage #(.WIDTH(RES_W)) u_stage_s2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s1),
		.up_stall (stall_s2),
		.up_data  (res),
		.dn_valid (out_valid),
		.dn_stall (out_stall),
		.dn_data  (data_s2)
	);

	assign {cmd_valid, cmd_write, cmd_address, cmd_data,
		test_phase, test_status, fail_address, fail_data} = data_s2;

	// Reads are only issued in the two verify passes
	`ASSERT_IMPLIES(a_read_in_verify, clk, arst_n, out_valid && cmd_valid && !cmd_write, test_phase == dpte_pkg::PH_VERIFY_CPL || test_phase == dpte_pkg::PH_VERIFY)
	// A bad mode result stops the test and issues nothing
	`ASSERT_IMPLIES(a_bad_mode_stops, clk, arst_n, out_valid && test_status == dpte_pkg::ST_BAD_MODE, !cmd_valid && test_phase == dpte_pkg::PH_IDLE)
	// A passed test has no recorded failure and no command
	`ASSERT_IMPLIES(a_pass_clean, clk, arst_n, out_valid && test_status == dpte_pkg::ST_PASSED, !cmd_valid && fail_address == '0 && fail_data == '0)
	// Backpressure only reaches the input when the result register is full
	`ASSERT_IMPLIES(a_stall_needs_full, clk, arst_n, in_stall, out_valid && out_stall && valid_s1)
	// An empty result register is filled by a waiting input transaction
	`ASSERT_NEXT(a_s1_drains, clk, arst_n, valid_s1 && !out_valid, out_valid)

endmodule

`default_nettype wire

>>> design/dpte_cfg.sv
// Configuration register file of the pattern test engine.
// Depends on dpte_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module dpte_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [dpte_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dpte_pkg::CFG_DATA_W-1:0]    cfg_data,
	output dpte_pkg::cfg_t                          cfg
);

	dpte_pkg::cfg_t cfg_q;

	// Register writes, one index per transaction; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address   <= '0;
			cfg_q.test_length    <= '0;
			cfg_q.test_mode      <= dpte_pkg::MODE_EXHAUSTIVE;
			cfg_q.data_pattern   <= dpte_pkg::PATTERN_RST;
			cfg_q.step_span      <= dpte_pkg::SPAN_RST;
			cfg_q.words_per_step <= dpte_pkg::WPS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dpte_pkg::REG_BASE_ADDRESS:   cfg_q.base_address   <= cfg_data;
				dpte_pkg::REG_TEST_LENGTH:    cfg_q.test_length    <= cfg_data;
				dpte_pkg::REG_TEST_MODE:      cfg_q.test_mode      <= cfg_data[1:0];
				dpte_pkg::REG_DATA_PATTERN:   cfg_q.data_pattern   <= cfg_data;
				dpte_pkg::REG_STEP_SPAN:      cfg_q.step_span      <= cfg_data[20:0];
				dpte_pkg::REG_WORDS_PER_STEP: cfg_q.words_per_step <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> design/dpte_stage.sv
// One valid/stall pipeline register stage of the pattern test engine.
// Generic over payload width; no package dependency.
`default_nettype none

module dpte_stage #(
	parameter int WIDTH = 33
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             up_valid,
	output logic                  up_stall,
	input  wire logic [WIDTH-1:0] up_data,
	output logic                  dn_valid,
	input  wire logic             dn_stall,
	output logic [WIDTH-1:0]      dn_data
);

	logic             valid_q;
	logic [WIDTH-1:0] data_q;
	logic             load;

	// Take a new transaction when empty or when the held one leaves this cycle
	assign up_stall = valid_q && dn_stall;
	assign load     = up_valid && !up_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= up_data;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

`default_nettype wire

>>> design/dpte_seq.sv
// Test sequencer of the pattern test engine: test state and per-transaction next state.
// Depends on dpte_pkg for operation, phase and status codes and cfg_t.
`default_nettype none

module dpte_seq #(
	parameter int ADDR_WIDTH = 32,
	parameter int DATA_WIDTH = 32,
	parameter int WORD_BYTES = 4,
	parameter int RES_WIDTH  = 2 + 2 * ADDR_WIDTH + 2 * DATA_WIDTH + 2 + 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fire,
	input  wire logic                  operation,
	input  wire logic [DATA_WIDTH-1:0] read_data,
	input  wire dpte_pkg::cfg_t        cfg,
	output logic [RES_WIDTH-1:0]       res
);

	// Compare width: holds an offset plus a span, and a 32-bit length
	localparam int CW = (ADDR_WIDTH >= 32) ? ADDR_WIDTH + 1 : 33;

	// Test state
	dpte_pkg::phase_t        phase_q,  phase_d;
	dpte_pkg::status_t       status_q, status_d;
	logic [ADDR_WIDTH-1:0]   group_q,  group_d;
	logic [7:0]              widx_q,   widx_d;
	logic                    war_q,    war_d;
	logic                    chk_q,    chk_d;
	logic [ADDR_WIDTH-1:0]   pend_q,   pend_d;
	logic [ADDR_WIDTH-1:0]   ffa_q,    ffa_d;
	logic [DATA_WIDTH-1:0]   ffd_q,    ffd_d;

	// Live configuration, decoded
	logic [DATA_WIDTH-1:0]   pat, cpl;
	logic                    mode_bad, sparse;
	logic [20:0]             span;
	logic [7:0]              cnt;
	logic [ADDR_WIDTH-1:0]   base_a;
	logic [CW-1:0]           len_c;

	// Region end check and pass rollover
	logic [ADDR_WIDTH-1:0]   offset;
	logic                    region_done;
	dpte_pkg::phase_t        phase_a;
	logic [ADDR_WIDTH-1:0]   grp_a, off_a;
	logic [7:0]              wi_a, wi_n, w;
	logic [ADDR_WIDTH-1:0]   word_off, cmd_addr;

	// Position advance unit
	logic [ADDR_WIDTH-1:0]   adv_grp_in, adv_off;
	logic [7:0]              adv_wi;
	logic [8:0]              wi_inc;
	logic                    wrap;
	logic [CW-1:0]           n_sum, n_clip;
	logic [ADDR_WIDTH-1:0]   adv_grp;
	logic [7:0]              adv_wi_next;

	// Command of this transaction
	logic                    cv, cw;
	logic [ADDR_WIDTH-1:0]   ca;
	logic [DATA_WIDTH-1:0]   cd;

	// Config decode
	assign pat      = DATA_WIDTH'(cfg.data_pattern);
	assign cpl      = ~pat;
	assign mode_bad = cfg.test_mode[1];
	assign sparse   = (cfg.test_mode == dpte_pkg::MODE_SPARSE);
	assign base_a   = ADDR_WIDTH'(cfg.base_address);
	assign len_c    = CW'(cfg.test_length);

	always_comb begin
		if (!sparse) begin
			span = 21'(WORD_BYTES);
			cnt  = 8'd1;
		end else begin
			span = (cfg.step_span < 21'(WORD_BYTES)) ? 21'(WORD_BYTES) : cfg.step_span;
			cnt  = (cfg.words_per_step == 8'd0) ? 8'd1 : cfg.words_per_step;
		end
	end

	// Region end: restart at base in the next pass, or finish
	assign offset      = group_q - base_a;
	assign region_done = CW'(offset) >= len_c;

	always_comb begin
		if (region_done) begin
			grp_a = base_a;
			off_a = '0;
			wi_a  = 8'd0;
			if (cfg.test_length == 32'd0 || phase_q == dpte_pkg::PH_VERIFY) begin
				phase_a = dpte_pkg::PH_IDLE;
			end else begin
				phase_a = dpte_pkg::phase_t'(phase_q + 2'd1);
			end
		end else begin
			grp_a   = group_q;
			off_a   = offset;
			wi_a    = widx_q;
			phase_a = phase_q;
		end
	end

	// Word within the group; final pass walks downward
	assign wi_n     = (wi_a >= cnt) ? 8'd0 : wi_a;
	assign w        = (phase_a == dpte_pkg::PH_VERIFY) ? (cnt - 8'd1 - wi_n) : wi_n;
	assign word_off = ADDR_WIDTH'(w) * ADDR_WIDTH'(WORD_BYTES);
	assign cmd_addr = grp_a + word_off;

	// Advance: next word, or next group clipped to the region end
	assign adv_grp_in = war_q ? group_q : grp_a;
	assign adv_off    = war_q ? offset  : off_a;
	assign adv_wi     = war_q ? widx_q  : wi_n;
	assign wi_inc     = {1'b0, adv_wi} + 9'd1;
	assign wrap       = wi_inc >= {1'b0, cnt};
	assign n_sum      = CW'(adv_off) + CW'(span);
	assign n_clip     = (n_sum > len_c) ? len_c : n_sum;
	assign adv_grp    = wrap ? (base_a + ADDR_WIDTH'(n_clip)) : adv_grp_in;
	assign adv_wi_next = wrap ? 8'd0 : wi_inc[7:0];

	// Next state and command
	always_comb begin
		phase_d  = phase_q;
		status_d = status_q;
		group_d  = group_q;
		widx_d   = widx_q;
		war_d    = war_q;
		chk_d    = chk_q;
		pend_d   = pend_q;
		ffa_d    = ffa_q;
		ffd_d    = ffd_q;
		cv = 1'b0;
		cw = 1'b0;
		ca = '0;
		cd = '0;
		if (operation == dpte_pkg::OP_START) begin
			group_d = base_a;
			widx_d  = 8'd0;
			war_d   = 1'b0;
			chk_d   = 1'b0;
			pend_d  = '0;
			ffa_d   = '0;
			ffd_d   = '0;
			if (mode_bad) begin
				status_d = dpte_pkg::ST_BAD_MODE;
				phase_d  = dpte_pkg::PH_IDLE;
			end else begin
				status_d = dpte_pkg::ST_RUNNING;
				phase_d  = dpte_pkg::PH_WRITE;
			end
		end else if (phase_q != dpte_pkg::PH_IDLE) begin
			if (mode_bad) begin
				status_d = dpte_pkg::ST_BAD_MODE;
				phase_d  = dpte_pkg::PH_IDLE;
				war_d    = 1'b0;
				chk_d    = 1'b0;
			end else if (war_q) begin
				// Second half of a pass-2 word: complement write, check pattern
				cv    = 1'b1;
				cw    = 1'b1;
				ca    = pend_q;
				cd    = cpl;
				war_d = 1'b0;
				chk_d = 1'b0;
				if (read_data != pat) begin
					status_d = dpte_pkg::ST_PAT_MISMATCH;
					ffa_d    = pend_q;
					ffd_d    = read_data;
					phase_d  = dpte_pkg::PH_IDLE;
				end else begin
					group_d = adv_grp;
					widx_d  = adv_wi_next;
				end
			end else if (chk_q && read_data != cpl) begin
				// Final pass read came back wrong
				chk_d    = 1'b0;
				status_d = dpte_pkg::ST_CPL_MISMATCH;
				ffa_d    = pend_q;
				ffd_d    = read_data;
				phase_d  = dpte_pkg::PH_IDLE;
			end else begin
				chk_d   = 1'b0;
				phase_d = phase_a;
				group_d = grp_a;
				widx_d  = wi_a;
				if (phase_a == dpte_pkg::PH_IDLE) begin
					status_d = dpte_pkg::ST_PASSED;
				end else begin
					cv = 1'b1;
					ca = cmd_addr;
					unique case (phase_a)
						dpte_pkg::PH_WRITE: begin
							cw      = 1'b1;
							cd      = pat;
							group_d = adv_grp;
							widx_d  = adv_wi_next;
						end
						dpte_pkg::PH_VERIFY_CPL: begin
							war_d  = 1'b1;
							chk_d  = 1'b1;
							pend_d = cmd_addr;
							widx_d = wi_n;
						end
						dpte_pkg::PH_VERIFY: begin
							chk_d   = 1'b1;
							pend_d  = cmd_addr;
							group_d = adv_grp;
							widx_d  = adv_wi_next;
						end
						default: ;
					endcase
				end
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= dpte_pkg::PH_IDLE;
			status_q <= dpte_pkg::ST_RUNNING;
			group_q  <= '0;
			widx_q   <= 8'd0;
			war_q    <= 1'b0;
			chk_q    <= 1'b0;
			pend_q   <= '0;
			ffa_q    <= '0;
			ffd_q    <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			status_q <= status_d;
			group_q  <= group_d;
			widx_q   <= widx_d;
			war_q    <= war_d;
			chk_q    <= chk_d;
			pend_q   <= pend_d;
			ffa_q    <= ffa_d;
			ffd_q    <= ffd_d;
		end
	end

	// Result transaction: command plus state after this item
	assign res = {cv, cw, ca, cd, phase_d, status_d, ffa_d, ffd_d};

endmodule

`default_nettype wire

>>> bench/dpte_command_check.sv
// Result checker for the memory pattern test engine bench: follows register writes,
// predicts every result from the accepted input transactions and compares the result channel.
// Depends on dpte_pkg only; it drives nothing into the engine.
module dpte_command_check (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_write,
	input  logic [dpte_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [dpte_pkg::CFG_DATA_W-1:0]           cfg_data,
	input  logic                                      in_valid,
	input  logic                                      in_stall,
	input  logic                                      operation,
	input  logic [31:0]                               read_data,
	input  logic                                      out_valid,
	input  logic                                      out_stall,
	input  logic                                      cmd_valid,
	input  logic                                      cmd_write,
	input  logic [31:0]                               cmd_address,
	input  logic [31:0]                               cmd_data,
	input  logic [1:0]                                test_phase,
	input  logic [2:0]                                test_status,
	input  logic [31:0]                               fail_address,
	input  logic [31:0]                               fail_data,
	output int                                        fail_count,
	output int                                        results_owed,
	output dpte_pkg::phase_t                          run_phase,
	output logic                                      read_checked,
	output logic [31:0]                               healthy_read
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_BYTES = 4;

	// One result transaction as the engine should produce it
	typedef struct packed {
		logic              cmd_valid;
		logic              cmd_write;
		logic [31:0]       cmd_address;
		logic [31:0]       cmd_data;
		dpte_pkg::phase_t  test_phase;
		dpte_pkg::status_t test_status;
		logic [31:0]       fail_address;
		logic [31:0]       fail_data;
	} engine_result_t;

	// Shadow registers and sequencer state
	dpte_pkg::cfg_t    regs;
	dpte_pkg::phase_t  cur_phase;
	dpte_pkg::status_t cur_status;
	logic [31:0]       group_addr;
	int unsigned       word_idx;
	logic              write_next;
	logic              check_next;
	logic [31:0]       pend_addr;
	logic [31:0]       first_fail_addr;
	logic [31:0]       first_fail_data;
	engine_result_t    owed_results[$];
	engine_result_t    want;

	// Hints for the stimulus: what a healthy memory returns for the pending read
	assign run_phase    = cur_phase;
	assign read_checked = check_next;
	assign healthy_read = write_next ? regs.data_pattern : ~regs.data_pattern;

	function automatic logic [63:0] span_bytes();
		if (regs.test_mode == dpte_pkg::MODE_EXHAUSTIVE)
			return WORD_BYTES;
		return (regs.step_span < WORD_BYTES) ? WORD_BYTES : regs.step_span;
	endfunction

	function automatic int unsigned word_count();
		if (regs.test_mode == dpte_pkg::MODE_EXHAUSTIVE || regs.words_per_step == 8'd0)
			return 1;
		return regs.words_per_step;
	endfunction

	function automatic logic [31:0] group_offset();
		return group_addr - regs.base_address;
	endfunction

	// Step to the next word; past the group end, jump one span (clamped to the region end)
	function automatic void next_word();
		logic [31:0] ofs;
		logic [63:0] reach;
		word_idx++;
		if (word_idx >= word_count()) begin
			ofs = group_offset();
			reach = {32'd0, ofs} + span_bytes();
			word_idx = 0;
			if (reach > {32'd0, regs.test_length})
				reach = {32'd0, regs.test_length};
			group_addr = regs.base_address + reach[31:0];
		end
	endfunction

	function automatic void stop_on_mismatch(dpte_pkg::status_t code, logic [31:0] addr,
			logic [31:0] data);
		cur_status = code;
		first_fail_addr = addr;
		first_fail_data = data;
		cur_phase = dpte_pkg::PH_IDLE;
	endfunction

	// Apply one input transaction and return the result it causes
	function automatic engine_result_t engine_step(dpte_pkg::op_t op, logic [31:0] rd);
		engine_result_t r;
		logic [31:0]    pat;
		logic [31:0]    cpl;
		logic           failed;
		int unsigned    cnt;
		int unsigned    w;
		r = '0;
		pat = regs.data_pattern;
		cpl = ~regs.data_pattern;
		failed = 1'b0;
		if (op == dpte_pkg::OP_START) begin
			group_addr = regs.base_address;
			word_idx = 0;
			write_next = 1'b0;
			check_next = 1'b0;
			pend_addr = '0;
			first_fail_addr = '0;
			first_fail_data = '0;
			if (regs.test_mode[1]) begin
				cur_status = dpte_pkg::ST_BAD_MODE;
				cur_phase = dpte_pkg::PH_IDLE;
			end else begin
				cur_status = dpte_pkg::ST_RUNNING;
				cur_phase = dpte_pkg::PH_WRITE;
			end
		end else if (cur_phase != dpte_pkg::PH_IDLE) begin
			if (regs.test_mode[1]) begin
				cur_status = dpte_pkg::ST_BAD_MODE;
				cur_phase = dpte_pkg::PH_IDLE;
				write_next = 1'b0;
				check_next = 1'b0;
			end else if (write_next) begin
				// second half of a pass-2 word: complement write, pattern check
				r.cmd_valid = 1'b1;
				r.cmd_write = 1'b1;
				r.cmd_address = pend_addr;
				r.cmd_data = cpl;
				write_next = 1'b0;
				check_next = 1'b0;
				if (rd != pat)
					stop_on_mismatch(dpte_pkg::ST_PAT_MISMATCH, pend_addr, rd);
				else
					next_word();
			end else begin
				if (check_next) begin
					check_next = 1'b0;
					if (rd != cpl) begin
						stop_on_mismatch(dpte_pkg::ST_CPL_MISMATCH, pend_addr, rd);
						failed = 1'b1;
					end
				end
				// skip over finished (or empty) passes
				while (!failed && cur_phase != dpte_pkg::PH_IDLE &&
						group_offset() >= regs.test_length) begin
					group_addr = regs.base_address;
					word_idx = 0;
					if (cur_phase == dpte_pkg::PH_VERIFY) begin
						cur_phase = dpte_pkg::PH_IDLE;
						cur_status = dpte_pkg::ST_PASSED;
					end else begin
						cur_phase = dpte_pkg::phase_t'(cur_phase + 2'd1);
					end
				end
				if (!failed && cur_phase != dpte_pkg::PH_IDLE) begin
					cnt = word_count();
					if (word_idx >= cnt)
						word_idx = 0;
					w = (cur_phase == dpte_pkg::PH_VERIFY) ? cnt - 1 - word_idx : word_idx;
					r.cmd_address = group_addr + w * WORD_BYTES;
					r.cmd_valid = 1'b1;
					case (cur_phase)
						dpte_pkg::PH_WRITE: begin
							r.cmd_write = 1'b1;
							r.cmd_data = pat;
							next_word();
						end
						dpte_pkg::PH_VERIFY_CPL: begin
							write_next = 1'b1;
							check_next = 1'b1;
							pend_addr = r.cmd_address;
						end
						default: begin
							check_next = 1'b1;
							pend_addr = r.cmd_address;
							next_word();
						end
					endcase
				end
			end
		end
		r.test_phase = cur_phase;
		r.test_status = cur_status;
		r.fail_address = first_fail_addr;
		r.fail_data = first_fail_data;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_val,
			logic [31:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %h, got %h", name, exp_val, got_val);
			fail_count++;
		end
	endfunction

	// Track register writes, predict on input transactions, compare result transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.base_address = '0;
			regs.test_length = '0;
			regs.test_mode = dpte_pkg::MODE_EXHAUSTIVE;
			regs.data_pattern = dpte_pkg::PATTERN_RST;
			regs.step_span = dpte_pkg::SPAN_RST;
			regs.words_per_step = dpte_pkg::WPS_RST;
			cur_phase = dpte_pkg::PH_IDLE;
			cur_status = dpte_pkg::ST_RUNNING;
			group_addr = '0;
			word_idx = 0;
			write_next = 1'b0;
			check_next = 1'b0;
			pend_addr = '0;
			first_fail_addr = '0;
			first_fail_data = '0;
			owed_results.delete();
			fail_count = 0;
			results_owed = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$error("result transaction with no expectation waiting");
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("cmd_valid", want.cmd_valid, cmd_valid);
					check_field("cmd_write", want.cmd_write, cmd_write);
					check_field("cmd_address", want.cmd_address, cmd_address);
					check_field("cmd_data", want.cmd_data, cmd_data);
					check_field("test_phase", want.test_phase, test_phase);
					check_field("test_status", want.test_status, test_status);
					check_field("fail_address", want.fail_address, fail_address);
					check_field("fail_data", want.fail_data, fail_data);
				end
			end
			if (in_valid && !in_stall)
				owed_results.push_back(engine_step(dpte_pkg::op_t'(operation), read_data));
			if (cfg_write) begin
				case (cfg_index)
					dpte_pkg::REG_BASE_ADDRESS:   regs.base_address = cfg_data;
					dpte_pkg::REG_TEST_LENGTH:    regs.test_length = cfg_data;
					dpte_pkg::REG_TEST_MODE:      regs.test_mode = cfg_data[1:0];
					dpte_pkg::REG_DATA_PATTERN:   regs.data_pattern = cfg_data;
					dpte_pkg::REG_STEP_SPAN:      regs.step_span = cfg_data[20:0];
					dpte_pkg::REG_WORDS_PER_STEP: regs.words_per_step = cfg_data[7:0];
					default: ;
				endcase
			end
			results_owed = owed_results.size();
		end
	end

endmodule

>>> bench/tb_dram_pattern_test_engine.sv
// Top of the memory pattern test engine bench: clock, reset, register setup and stimulus.
// Runs short directed tests, then random test runs under several idle/stall mixes.
// Depends on dpte_pkg, dram_pattern_test_engine and dpte_command_check.
module tb_dram_pattern_test_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TEST_ITEMS = 950;
	localparam int TEST_ITEM_CAP = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 20000;
	localparam int CORRUPT_PERMILLE = 15;
	localparam int WORD_BYTES = 4;
	localparam logic [1:0] MODE_BAD = 2'd2;
	localparam logic [1:0] MODE_BAD_ALT = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_write = 1'b0;
	logic [dpte_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dpte_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic                            operation = 1'b0;
	logic [31:0]                     read_data = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic                            cmd_valid;
	logic                            cmd_write;
	logic [31:0]                     cmd_address;
	logic [31:0]                     cmd_data;
	logic [1:0]                      test_phase;
	logic [2:0]                      test_status;
	logic [31:0]                     fail_address;
	logic [31:0]                     fail_data;
	int                              fail_count;
	int                              results_owed;
	dpte_pkg::phase_t                run_phase;
	logic                            read_checked;
	logic [31:0]                     healthy_read;
	int                              send_idle_pct = 0;
	int                              stall_pct = 0;
	int                              items_sent = 0;

	dram_pattern_test_engine uut (.*);
	dpte_command_check cmd_check (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver backpressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Present one transaction and hold it until accepted; returns at a falling edge.
	// A checked read normally gets what a healthy memory would return.
	// The idle/stall mix follows the number of transactions sent so far.
	task automatic send_item(input dpte_pkg::op_t op, input int corrupt_permille);
		logic [31:0] flip;
		if (items_sent < 240) begin
			send_idle_pct = 0;
			stall_pct = 0;
		end else if (items_sent < 480) begin
			send_idle_pct = 47;
			stall_pct = 0;
		end else if (items_sent < 720) begin
			send_idle_pct = 0;
			stall_pct = 47;
		end else begin
			send_idle_pct = 18;
			stall_pct = 18;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		flip = '0;
		if ($urandom_range(999) < corrupt_permille)
			flip = ($urandom_range(1) ? $urandom : 32'd0) | (32'd1 << $urandom_range(31));
		in_valid <= 1'b1;
		operation <= op;
		read_data <= read_checked ? (healthy_read ^ flip) : $urandom;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop sending and wait until every expected result has come back or DRAIN_LIMIT is reached
	task automatic drain();
		int k;
		in_valid <= 1'b0;
		k = 0;
		do begin
			@(negedge clk);
			k++;
		end while (results_owed != 0 && k < DRAIN_LIMIT);
	endtask

	// Write the selected registers; narrow ones sometimes carry junk in the upper bits
	task automatic load_regs(input dpte_pkg::cfg_t c, input logic [5:0] pick);
		logic [dpte_pkg::CFG_IDX_W-1:0]  reg_ids[6];
		logic [dpte_pkg::CFG_DATA_W-1:0] vals[6];
		logic [dpte_pkg::CFG_DATA_W-1:0] junk;
		reg_ids = '{dpte_pkg::REG_BASE_ADDRESS, dpte_pkg::REG_TEST_LENGTH,
			dpte_pkg::REG_TEST_MODE, dpte_pkg::REG_DATA_PATTERN,
			dpte_pkg::REG_STEP_SPAN, dpte_pkg::REG_WORDS_PER_STEP};
		junk = ($urandom_range(3) == 0) ? $urandom : '0;
		vals[0] = c.base_address;
		vals[1] = c.test_length;
		vals[2] = {junk[31:2], c.test_mode};
		vals[3] = c.data_pattern;
		vals[4] = {junk[31:21], c.step_span};
		vals[5] = {junk[31:8], c.words_per_step};
		for (int i = 0; i < 6; i++) begin
			if (pick[i]) begin
				cfg_write <= 1'b1;
				cfg_index <= reg_ids[i];
				cfg_data <= vals[i];
				@(negedge clk);
			end
		end
		cfg_write <= 1'b0;
	endtask

	function automatic dpte_pkg::cfg_t random_setup();
		dpte_pkg::cfg_t c;
		int unsigned    pick;
		int unsigned    span_eff;
		pick = $urandom_range(99);
		if (pick < 45)
			c.test_mode = dpte_pkg::MODE_EXHAUSTIVE;
		else if (pick < 92)
			c.test_mode = dpte_pkg::MODE_SPARSE;
		else
			c.test_mode = $urandom_range(1) ? MODE_BAD : MODE_BAD_ALT;
		pick = $urandom_range(99);
		if (pick < 70)
			c.base_address = $urandom & ~32'h3;
		else if (pick < 85)
			c.base_address = 32'hFFFF_FF00 | ($urandom_range(255) & ~32'h3);
		else
			c.base_address = $urandom;
		pick = $urandom_range(99);
		if (pick < 10)
			c.data_pattern = 32'h0;
		else if (pick < 20)
			c.data_pattern = 32'hFFFF_FFFF;
		else
			c.data_pattern = $urandom;
		pick = $urandom_range(99);
		if (pick < 55)
			c.step_span = 21'($urandom_range(4, 64));
		else if (pick < 70)
			c.step_span = 21'($urandom_range(3));
		else if (pick < 85)
			c.step_span = 21'($urandom);
		else if (pick < 93)
			c.step_span = 21'h1F_FFFF;
		else
			c.step_span = 21'd1048576;
		pick = $urandom_range(99);
		if (pick < 65)
			c.words_per_step = 8'($urandom_range(1, 4));
		else if (pick < 80)
			c.words_per_step = 8'd0;
		else if (pick < 96)
			c.words_per_step = 8'($urandom_range(5, 16));
		else
			c.words_per_step = 8'd255;
		span_eff = (c.step_span < WORD_BYTES) ? WORD_BYTES : c.step_span;
		// short regions so that most runs reach the end of pass 3
		pick = $urandom_range(99);
		if (pick < 4)
			c.test_length = 32'hFFFF_FFFF;
		else if (pick < 8)
			c.test_length = 32'h0;
		else if (c.test_mode == dpte_pkg::MODE_SPARSE)
			c.test_length = $urandom_range(1, 3 * span_eff);
		else
			c.test_length = $urandom_range(1, 48);
		return c;
	endfunction

	// Start a test and advance it until it stops (or the item cap or total is hit)
	task automatic run_test(input int corrupt_permille, input bit noisy);
		int n;
		send_item(dpte_pkg::OP_START, 0);
		n = 0;
		while (run_phase != dpte_pkg::PH_IDLE && n < TEST_ITEM_CAP &&
				items_sent < TEST_ITEMS) begin
			if (noisy && $urandom_range(199) == 0)
				send_item(dpte_pkg::OP_START, 0);
			else
				send_item(dpte_pkg::OP_ADVANCE, corrupt_permille);
			n++;
			// live register change in the middle of a run
			if (noisy && $urandom_range(299) == 0) begin
				drain();
				load_regs(random_setup(), 6'b1 << $urandom_range(5));
			end
		end
		// advances after the test has stopped leave the outputs alone
		if (noisy)
			repeat ($urandom_range(2)) send_item(dpte_pkg::OP_ADVANCE, 0);
	endtask

	initial begin : stimulus
		dpte_pkg::cfg_t c;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset register values: advance while idle, then an empty region passes at once
		send_item(dpte_pkg::OP_ADVANCE, 0);
		send_item(dpte_pkg::OP_START, 0);
		send_item(dpte_pkg::OP_ADVANCE, 0);
		send_item(dpte_pkg::OP_ADVANCE, 0);
		drain();

		// Region wrapping past the top of the address space, all-ones pattern
		c.base_address = 32'hFFFF_FFF8;
		c.test_length = 32'd8;
		c.test_mode = dpte_pkg::MODE_EXHAUSTIVE;
		c.data_pattern = 32'hFFFF_FFFF;
		c.step_span = 21'h1F_FFFF;
		c.words_per_step = 8'd255;
		load_regs(c, 6'h3F);
		run_test(0, 1'b0);
		drain();

		// Invalid modes refuse to start
		c.test_mode = MODE_BAD;
		load_regs(c, 6'h04);
		send_item(dpte_pkg::OP_START, 0);
		send_item(dpte_pkg::OP_ADVANCE, 0);
		drain();
		c.test_mode = MODE_BAD_ALT;
		load_regs(c, 6'h04);
		send_item(dpte_pkg::OP_START, 0);
		drain();

		// Mode turned invalid while a test is running
		c.base_address = 32'h0000_0100;
		c.test_length = 32'd16;
		c.test_mode = dpte_pkg::MODE_EXHAUSTIVE;
		c.data_pattern = 32'h0;
		load_regs(c, 6'h0F);
		send_item(dpte_pkg::OP_START, 0);
		repeat (3) send_item(dpte_pkg::OP_ADVANCE, 0);
		drain();
		c.test_mode = MODE_BAD_ALT;
		load_regs(c, 6'h04);
		send_item(dpte_pkg::OP_ADVANCE, 0);

		// Random test runs under changing idle/stall mixes
		while (items_sent < TEST_ITEMS) begin
			drain();
			load_regs(random_setup(), ($urandom_range(7) == 0) ? 6'($urandom) : 6'h3F);
			run_test(CORRUPT_PERMILLE, 1'b1);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (results_owed != 0)
			$error("%0d expected results never arrived", results_owed);
		if (fail_count == 0 && results_owed == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog
	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
